FILE: hdl/mrb_pkg.sv
// Package with the constants, types and state codes of the maximal rectangle unit.
`timescale 1ns / 1ps

package mrb_pkg;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 1024;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int CNT_W    = $clog2(MAX_COLS + 1);
	localparam int HT_W     = $clog2(MAX_ROWS + 1);
	localparam int AREA_W   = 17;
	localparam int PROD_W   = HT_W + CNT_W;
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HT,
		ST_CMP,
		ST_POP_CMP,
		ST_FLUSH,
		ST_POP_FLUSH,
		ST_EMIT
	} mrb_state_t;

	// One stack entry: the column and the height that column had in this row.
	typedef struct packed {
		logic [COL_W-1:0] idx;
		logic [HT_W-1:0]  height;
	} stk_entry_t;

	typedef struct packed {
		logic             we;
		logic             clear;
		logic [COL_W-1:0] waddr;
		logic [HT_W-1:0]  wdata;
	} ht_wr_t;

	typedef struct packed {
		logic             valid;
		logic [HT_W-1:0]  height;
		logic [CNT_W-1:0] span;
	} score_req_t;

endpackage

FILE: hdl/mrb_if.sv
// Interfaces of the cell input channel and the area result channel.
`timescale 1ns / 1ps

interface mrb_cell_if;
	logic valid;
	logic ready;
	logic cell_bit;
	logic last_cell;
	modport source (output valid, output cell_bit, output last_cell, input ready);
	modport sink (input valid, input cell_bit, input last_cell, output ready);
endinterface

interface mrb_area_if;
	import mrb_pkg::*;
	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] max_area;
	modport source (output valid, output max_area, input ready);
	modport sink (input valid, input max_area, output ready);
endinterface

FILE: hdl/mrb_height_mem.sv
// Column height memory with per-column valid bits that read as zero until written.
`timescale 1ns / 1ps

module mrb_height_mem
	import mrb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [COL_W-1:0] raddr,
	output logic [HT_W-1:0]  rdata,
	input  ht_wr_t           wr
);

	logic [HT_W-1:0]     mem [MAX_COLS];
	logic [MAX_COLS-1:0] vld_q;
	logic [HT_W-1:0]     rdata_q;
	logic                rvld_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr];
			if (wr.clear) begin
				vld_q <= '0;
			end else if (wr.we) begin
				vld_q[wr.waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

FILE: hdl/mrb_stack_mem.sv
// Index stack memory: one write port and one registered read port.
`timescale 1ns / 1ps

module mrb_stack_mem
	import mrb_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [COL_W-1:0] waddr,
	input  stk_entry_t       wdata,
	input  logic [COL_W-1:0] raddr,
	output stk_entry_t       rdata
);

	stk_entry_t mem [MAX_COLS];
	stk_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/mrb_score.sv
// Area scoring: registered height times span, then saturate and keep the maximum.
`timescale 1ns / 1ps

module mrb_score
	import mrb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  score_req_t        req,
	input  logic              clear,
	output logic [AREA_W-1:0] best
);

	logic [PROD_W-1:0] prod_s1;
	logic              vld_s1;
	logic [AREA_W-1:0] best_q;
	logic [AREA_W-1:0] sat;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(req.height) * PROD_W'(req.span);
	end

	assign sat = (prod_s1 > PROD_W'(AREA_MAX)) ? AREA_MAX : prod_s1[AREA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			best_q <= '0;
		end else begin
			vld_s1 <= req.valid;
			if (clear) begin
				best_q <= '0;
			end else if (vld_s1 && sat > best_q) begin
				best_q <= sat;
			end
		end
	end

	assign best = best_q;

`ifndef SYNTH
	// A product still in flight when the best value is cleared would be lost.
	a_no_clear_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(clear && vld_s1))
		else $error("best area cleared while a product is pending");
`endif

endmodule

FILE: hdl/maximal_rectangle_binary_matrix_unit.sv
// Top level: sequencer for the histogram and monotonic stack area search.
//
//   channel    dir  handshake      payload
//   cell_in    in   valid/ready    cell_bit, last_cell
//   area_out   out  valid/ready    max_area (17 bits)
//   cfg        in   cfg_we         cfg_wdata = row_width (7 bits)
//
// A cell passes through accept, height read, and compare and push; every stack pop
// adds a pop state and a return to compare, as the stack memory read is registered.
// A row end flushes the stack: a flush state, then a pop and a flush per remaining entry.
// A last cell adds a state that loads the result register, and waits there while
// an earlier result is still untaken. Reset needs no clearing pass.
`timescale 1ns / 1ps

module maximal_rectangle_binary_matrix_unit
	import mrb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	mrb_cell_if.sink     cell_in,
	mrb_area_if.source   area_out
);

	mrb_state_t        state_q, state_d;
	logic [6:0]        row_width_q;
	logic [COL_W-1:0]  col_pos_q;
	logic [COL_W-1:0]  j_q;
	logic              bit_q;
	logic              last_q;
	logic [HT_W-1:0]   cur_q;
	logic [CNT_W-1:0]  count_q;
	stk_entry_t        top_q;
	logic              out_valid_q;
	logic [AREA_W-1:0] area_q;

	logic [HT_W-1:0]   ht_rdata;
	logic [HT_W-1:0]   ht_next;
	ht_wr_t            ht_wr;
	stk_entry_t        stk_rdata;
	logic              stk_we;
	score_req_t        score_req;
	logic [AREA_W-1:0] best;
	logic              score_clear;

	logic              accept;
	logic [CNT_W-1:0]  width_eff;
	logic [CNT_W-1:0]  j_plus1;
	logic              row_end;
	logic              pop_now;
	logic              out_free;
	logic [CNT_W-1:0]  span_end;
	logic [CNT_W-1:0]  span_left;

	assign accept    = cell_in.valid && cell_in.ready;
	assign width_eff = (row_width_q == '0) ? CNT_W'(1)
		: (row_width_q > 7'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(row_width_q);
	assign j_plus1   = CNT_W'(j_q) + CNT_W'(1);
	assign row_end   = last_q || (j_plus1 >= width_eff);
	assign pop_now   = (count_q != '0) && (top_q.height > cur_q);
	assign out_free  = !out_valid_q || area_out.ready;

	always_comb begin
		if (bit_q) begin
			ht_next = (ht_rdata < HT_W'(MAX_ROWS)) ? ht_rdata + HT_W'(1) : HT_W'(MAX_ROWS);
		end else begin
			ht_next = '0;
		end
	end

	// A pop in the compare phase ends its span at the current column, a flush pop
	// just after it.
	assign span_end  = (state_q == ST_POP_FLUSH) ? j_plus1 : CNT_W'(j_q);
	assign span_left = (count_q >= CNT_W'(2)) ? CNT_W'(stk_rdata.idx) + CNT_W'(1) : '0;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HT;
				end
			end
			ST_HT: state_d = ST_CMP;
			ST_CMP: begin
				if (pop_now) begin
					state_d = ST_POP_CMP;
				end else if (row_end) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_POP_CMP: state_d = ST_CMP;
			ST_FLUSH: begin
				if (count_q != '0) begin
					state_d = ST_POP_FLUSH;
				end else if (last_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_POP_FLUSH: state_d = ST_FLUSH;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		ht_wr            = '0;
		ht_wr.waddr      = j_q;
		ht_wr.wdata      = ht_next;
		stk_we           = 1'b0;
		score_req        = '0;
		score_req.height = top_q.height;
		score_req.span   = (span_end >= span_left) ? span_end - span_left : '0;
		score_clear      = 1'b0;
		cell_in.ready    = 1'b0;
		unique case (state_q)
			ST_IDLE:      cell_in.ready = 1'b1;
			ST_HT:        ht_wr.we = 1'b1;
			ST_CMP:       stk_we = !pop_now && (count_q < CNT_W'(MAX_COLS));
			ST_POP_CMP,
			ST_POP_FLUSH: score_req.valid = 1'b1;
			ST_FLUSH:     ;
			ST_EMIT: begin
				ht_wr.clear = out_free;
				score_clear = out_free;
			end
			default:      ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_q  <= cell_in.cell_bit;
			last_q <= cell_in.last_cell;
			j_q    <= col_pos_q;
		end
		if (state_q == ST_HT) begin
			cur_q <= ht_next;
		end
		if (state_q == ST_EMIT && out_free) begin
			area_q <= best;
		end
		if (stk_we) begin
			top_q <= '{idx: j_q, height: cur_q};
		end else if (score_req.valid) begin
			top_q <= stk_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_width_q <= 7'(MAX_COLS);
			col_pos_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				row_width_q <= cfg_wdata;
			end
			if (state_q == ST_CMP && !pop_now) begin
				col_pos_q <= row_end ? '0 : j_plus1[COL_W-1:0];
			end
			if (stk_we) begin
				count_q <= count_q + CNT_W'(1);
			end else if (score_req.valid) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (area_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign area_out.valid    = out_valid_q;
	assign area_out.max_area = area_q;

	mrb_height_mem u_height (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (col_pos_q),
		.rdata  (ht_rdata),
		.wr     (ht_wr)
	);

	// The stack read always looks at the entry just below the cached top.
	mrb_stack_mem u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (count_q[COL_W-1:0]),
		.wdata ('{idx: j_q, height: cur_q}),
		.raddr (COL_W'(count_q - CNT_W'(2))),
		.rdata (stk_rdata)
	);

	mrb_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (score_req),
		.clear  (score_clear),
		.best   (best)
	);

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_COLS))
		else $error("stack count above capacity");

	a_empty_at_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> count_q == '0)
		else $error("result emitted with entries left on the stack");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		score_req.valid |-> count_q != '0)
		else $error("pop from an empty stack");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the maximal rectangle unit with its own area predictor.
`timescale 1ns / 1ps

module tb;
	import mrb_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int ZERO_WIDTH_CELLS = 6;
	localparam int SEGMENT_CELLS = 50;

	// Histogram and stack model plus the queue of areas still to come.
	class area_checker;
		bit [HT_W-1:0]   heights [MAX_COLS];
		bit [COL_W-1:0]  col_stack [MAX_COLS];
		bit [CNT_W-1:0]  depth;
		bit [COL_W-1:0]  col_pos;
		bit [AREA_W-1:0] best;
		bit [6:0]        row_width;
		bit [AREA_W-1:0] expected_areas [$];
		int              errors;

		function new();
			clear_matrix();
			row_width = 7'd64;
			errors = 0;
		endfunction

		function void clear_matrix();
			foreach (heights[i])
				heights[i] = '0;
			depth = '0;
			col_pos = '0;
			best = '0;
		endfunction

		function int pending();
			return expected_areas.size();
		endfunction

		// Pop one column and score its height over the span that ends before end_col.
		function void pop_span(int unsigned end_col);
			bit [COL_W-1:0] top;
			int unsigned left, span, area;
			top = col_stack[depth - 1];
			depth--;
			left = (depth > 0) ? col_stack[depth - 1] + 1 : 0;
			span = (end_col >= left) ? end_col - left : 0;
			area = heights[top] * span;
			if (area > AREA_MAX)
				area = AREA_MAX;
			if (area > best)
				best = AREA_W'(area);
		endfunction

		function void note_cell(bit cell_val, bit last);
			int unsigned width, j, cur;
			if (row_width == 0)
				width = 1;
			else if (row_width > MAX_COLS)
				width = MAX_COLS;
			else
				width = row_width;
			j = col_pos;
			if (j >= MAX_COLS)
				j = MAX_COLS - 1;
			if (cell_val) begin
				if (heights[j] < MAX_ROWS)
					heights[j]++;
			end else begin
				heights[j] = '0;
			end
			cur = heights[j];
			while (depth > 0 && heights[col_stack[depth - 1]] > cur)
				pop_span(j);
			if (depth < MAX_COLS) begin
				col_stack[depth] = COL_W'(j);
				depth++;
			end
			if (last || j + 1 >= width) begin
				while (depth > 0)
					pop_span(j + 1);
				col_pos = '0;
			end else begin
				col_pos = COL_W'(j + 1);
			end
			if (last) begin
				expected_areas.push_back(best);
				clear_matrix();
			end
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		task check_area(bit [AREA_W-1:0] got);
			bit [AREA_W-1:0] want;
			if (expected_areas.size() == 0) begin
				report($sformatf("area %0d arrived with nothing expected", got));
			end else begin
				want = expected_areas.pop_front();
				if (got !== want)
					report($sformatf("max_area %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_wdata;

	mrb_cell_if cell_if ();
	mrb_area_if area_if ();

	maximal_rectangle_binary_matrix_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cell_in  (cell_if),
		.area_out (area_if)
	);

	area_checker board;
	int send_idle_pct;
	int stall_pct;
	int hold_trigger;
	int hold_seen;
	int hold_count;
	int sent_cells;
	int cycle_count;

	always #6 clk = ~clk;

	// Result side: check every transfer, then decide ready for the next cycle.
	always @(posedge clk) begin
		if (area_if.valid && area_if.ready)
			board.check_area(area_if.max_area);
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_count = HOLD_CYCLES;
		end
		if (hold_count > 0) begin
			hold_count--;
			area_if.ready <= 1'b0;
		end else begin
			area_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[%0t] timeout with %0d areas outstanding", $realtime, board.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task send_cell(bit cell_val, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			cell_if.valid <= 1'b0;
			@(posedge clk);
		end
		cell_if.valid <= 1'b1;
		cell_if.cell_bit <= cell_val;
		cell_if.last_cell <= last;
		do
			@(posedge clk);
		while (!cell_if.ready);
		board.note_cell(cell_val, last);
		sent_cells++;
	endtask

	// Sends count bits, most significant first; the final one is flagged as last if asked.
	task send_pattern(logic [63:0] pattern, int count, bit with_last);
		for (int k = count - 1; k >= 0; k--)
			send_cell(pattern[k], with_last && k == 0);
	endtask

	// Stops offering cells and waits until the block has delivered everything and gone quiet.
	task wait_areas_idle();
		cell_if.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_row_width(bit [6:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.row_width = value;
	endtask

	function int eff_width(bit [6:0] value);
		if (value == 0)
			return 1;
		if (value > MAX_COLS)
			return MAX_COLS;
		return int'(value);
	endfunction

	task send_matrix(int width);
		int rows, cells, ones_pct;
		rows = $urandom_range(1, (width <= 4) ? 8 : (width <= 16) ? 4 : 1);
		cells = rows * width;
		// A quarter of the matrices stop early, often in the middle of a row.
		if ($urandom_range(3) == 0)
			cells = $urandom_range(1, cells);
		case ($urandom_range(3))
			0: ones_pct = 50;
			1: ones_pct = 80;
			2: ones_pct = 95;
			default: ones_pct = 100;
		endcase
		for (int k = 0; k < cells; k++)
			send_cell($urandom_range(99) < ones_pct, k == cells - 1);
	endtask

	bit [6:0] width_plan [8];
	int start_cells;

	initial begin
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cell_if.valid = 1'b0;
		cell_if.cell_bit = 1'b0;
		cell_if.last_cell = 1'b0;
		area_if.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_trigger = 0;
		hold_seen = 0;
		hold_count = 0;
		sent_cells = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed matrices: all ones, all zeros, a last cell in mid-row, a single cell.
		set_row_width(7'd3);
		send_pattern(9'b111_111_111, 9, 1'b1);
		send_pattern(3'b000, 3, 1'b0);
		send_pattern(3'b000, 3, 1'b1);
		send_pattern(5'b101_11, 5, 1'b1);
		send_pattern(1'b1, 1, 1'b1);
		// Shrink the width while the row is two columns in: the next cell ends the row.
		wait_areas_idle();
		send_pattern(2'b11, 2, 1'b0);
		wait_areas_idle();
		set_row_width(7'd1);
		send_pattern(2'b11, 2, 1'b1);

		// A width of zero acts as one column, so a run of ones stacks up in column zero.
		wait_areas_idle();
		set_row_width(7'd0);
		for (int k = 0; k < ZERO_WIDTH_CELLS; k++)
			send_cell(1'b1, k == ZERO_WIDTH_CELLS - 1);

		width_plan[0] = 7'd64;
		width_plan[1] = 7'd127;
		width_plan[2] = 7'd1;
		width_plan[3] = 7'd5;
		width_plan[4] = 7'($urandom_range(2, 12));
		width_plan[5] = 7'd70;
		width_plan[6] = 7'($urandom_range(1, 64));
		width_plan[7] = 7'd3;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 61; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 61; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			for (int s = 0; s < 2; s++) begin
				wait_areas_idle();
				set_row_width(width_plan[phase * 2 + s]);
				// Starve the result side for a while so that the block backs up to its input.
				if (phase == 2 && s == 0)
					hold_trigger++;
				start_cells = sent_cells;
				while (sent_cells - start_cells < SEGMENT_CELLS)
					send_matrix(eff_width(width_plan[phase * 2 + s]));
			end
		end

		wait_areas_idle();
		if (board.errors == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
